// File: hdl/limit_order_matcher_assert.svh
// Assertion macros for the limit order matcher.
// Needs clk_i and rst_ni in the including scope.
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH

// same-cycle implication
`define LOM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lom_pkg.sv
// Package for the limit order matcher: payload types, book entry, row operations.
// No dependencies.
package lom_pkg;

  localparam int unsigned OrdersPerSideDefault = 32;
  localparam int unsigned IdW    = 32;
  localparam int unsigned PriceW = 20;
  localparam int unsigned QtyW   = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_ZERO_QTY = 2'd2
  } status_e;

  typedef struct packed {
    logic              side;
    logic [IdW-1:0]    order_id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   quantity;
  } order_t;

  typedef struct packed {
    logic              has_trade;
    logic [IdW-1:0]    buy_id;
    logic [IdW-1:0]    sell_id;
    logic [PriceW-1:0] trade_price;
    logic [QtyW-1:0]   trade_quantity;
    logic [1:0]        status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              vld;
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } entry_t;

  typedef struct packed {
    logic            pop;
    logic            dec;
    logic            ins;
    logic [QtyW-1:0] dec_amt;
    entry_t          ins_entry;
  } row_op_t;

endpackage

// File: hdl/lom_cell.sv
// One book slot: holds an entry, shifts toward front on pop, away on insert, lowers its quantity on a decrement.
// Depends on lom_pkg.
module lom_cell #(
  parameter bit IS_ASK = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lom_pkg::row_op_t op_i,
  input  lom_pkg::entry_t prev_i,
  input  logic            prev_after_i,
  input  lom_pkg::entry_t next_i,
  output lom_pkg::entry_t entry_o,
  output logic            after_o
);
  import lom_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    if (IS_ASK) begin
      after_o = ent_q.vld && (ent_q.price <= op_i.ins_entry.price);
    end else begin
      after_o = ent_q.vld && (ent_q.price >= op_i.ins_entry.price);
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (op_i.pop) begin
      ent_d = next_i;
    end else if (op_i.dec) begin
      ent_d.qty = ent_q.qty - op_i.dec_amt;
    end else if (op_i.ins && !after_o) begin
      ent_d = prev_after_i ? op_i.ins_entry : prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign entry_o = ent_q;
endmodule

// File: hdl/lom_row.sv
// One side of the book as a chain of lom_cell slots, best entry at slot zero.
// Depends on lom_pkg and lom_cell.
module lom_row #(
  parameter int unsigned ORDERS_PER_SIDE = lom_pkg::OrdersPerSideDefault,
  parameter bit          IS_ASK          = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lom_pkg::row_op_t op_i,
  output lom_pkg::entry_t  front0_o,
  output lom_pkg::entry_t  front1_o,
  output logic             full_o
);
  import lom_pkg::*;

  entry_t ents [ORDERS_PER_SIDE];
  logic   after [ORDERS_PER_SIDE];

  genvar g;
  for (g = 0; g < ORDERS_PER_SIDE; g++) begin : g_cell
    row_op_t cop;
    entry_t  prev, next;
    logic    prev_after;
    always_comb begin
      cop = op_i;
      if (g != 0) begin
        cop.dec = 1'b0;
      end
    end
    if (g == 0) begin : g_first
      assign prev       = op_i.ins_entry;
      assign prev_after = 1'b0;
    end else begin : g_mid
      assign prev       = ents[g-1];
      assign prev_after = after[g-1];
    end
    if (g == ORDERS_PER_SIDE - 1) begin : g_tail
      assign next = '0;
    end else begin : g_body
      assign next = ents[g+1];
    end
    lom_cell #(.IS_ASK(IS_ASK)) u_cell (
      .clk_i, .rst_ni, .op_i(cop), .prev_i(prev), .prev_after_i(prev_after),
      .next_i(next), .entry_o(ents[g]), .after_o(after[g])
    );
  end

  assign front0_o = ents[0];
  assign front1_o = ents[1];
  assign full_o   = ents[ORDERS_PER_SIDE-1].vld;
endmodule

// File: hdl/limit_order_matcher.sv
// Top level of the limit order matcher: order intake, match control, result register.
// Depends on lom_pkg, lom_row, limit_order_matcher_assert.svh.
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_stall_o  | in_data_i  (order_t)
//   out     | out | out_valid_o / out_stall_i| out_data_o (result_t)
//
// An order is taken in idle, then one result per cycle while the output is not stalled: k fills give
// k results, a plain rest or reject gives one. The result register sets the pace.
// Insertion and removal run as a shift in the cell rows, in the cycle of the result.
// Reset empties both books (slot valid bits clear at once).
// A stalled output holds the order in work; no new order is taken until its last result.
module limit_order_matcher #(
  parameter int unsigned ORDERS_PER_SIDE = lom_pkg::OrdersPerSideDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lom_pkg::order_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lom_pkg::result_t out_data_o
);
  import lom_pkg::*;
  `include "limit_order_matcher_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e  state_q, state_d;
  order_t  ord_q;
  result_t res_q, res_d;
  logic    out_vld_q;

  entry_t  bid0, bid1, ask0, ask1, opp0, opp1;
  logic    bid_full, ask_full, own_full;
  row_op_t bid_op, ask_op, opp_op, own_op;

  logic              zero, cross0, cross1, trade, empt, last, emit, ins_want, do_ins;
  logic [QtyW-1:0]   t, r, resid;
  status_e           status;

  lom_row #(.ORDERS_PER_SIDE(ORDERS_PER_SIDE), .IS_ASK(1'b0)) u_bid (
    .clk_i, .rst_ni, .op_i(bid_op), .front0_o(bid0), .front1_o(bid1), .full_o(bid_full)
  );
  lom_row #(.ORDERS_PER_SIDE(ORDERS_PER_SIDE), .IS_ASK(1'b1)) u_ask (
    .clk_i, .rst_ni, .op_i(ask_op), .front0_o(ask0), .front1_o(ask1), .full_o(ask_full)
  );

  assign opp0     = ord_q.side ? bid0 : ask0;
  assign opp1     = ord_q.side ? bid1 : ask1;
  assign own_full = ord_q.side ? ask_full : bid_full;

  always_comb begin
    zero   = (ord_q.quantity == '0);
    cross0 = opp0.vld && (ord_q.side ? (opp0.price >= ord_q.price)
                                     : (ord_q.price >= opp0.price));
    cross1 = opp1.vld && (ord_q.side ? (opp1.price >= ord_q.price)
                                     : (ord_q.price >= opp1.price));
    trade  = !zero && cross0;
    t      = (ord_q.quantity < opp0.qty) ? ord_q.quantity : opp0.qty;
    r      = ord_q.quantity - t;
    empt   = (opp0.qty == t);
    last   = zero || !trade || (r == '0) || !cross1;
    resid  = trade ? r : ord_q.quantity;
    ins_want = last && !zero && (resid != '0);
    do_ins = ins_want && !own_full;
    if (zero) begin
      status = STATUS_ZERO_QTY;
    end else if (ins_want && own_full) begin
      status = STATUS_FULL;
    end else begin
      status = STATUS_OK;
    end
    emit = (state_q == ST_BUSY) && (!out_vld_q || !out_stall_i);
  end

  always_comb begin
    opp_op = '0;
    own_op = '0;
    opp_op.dec_amt = t;
    opp_op.pop = emit && trade && empt;
    opp_op.dec = emit && trade && !empt;
    own_op.ins = emit && do_ins;
    own_op.ins_entry = '{vld: 1'b1, id: ord_q.order_id, price: ord_q.price, qty: resid};
    opp_op.ins_entry.price = ord_q.price;
    bid_op = ord_q.side ? opp_op : own_op;
    ask_op = ord_q.side ? own_op : opp_op;
  end

  always_comb begin
    res_d = '0;
    if (trade) begin
      res_d.has_trade      = 1'b1;
      res_d.buy_id         = ord_q.side ? opp0.id : ord_q.order_id;
      res_d.sell_id        = ord_q.side ? ord_q.order_id : opp0.id;
      res_d.trade_price    = ord_q.side ? ord_q.price : opp0.price;
      res_d.trade_quantity = t;
    end
    res_d.last   = last;
    res_d.status = last ? status : STATUS_OK;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_BUSY;
      ST_BUSY: if (emit && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      ord_q <= in_data_i;
    end else if (emit && trade) begin
      ord_q.quantity <= r;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  `LOM_ASSERT_NEXT(a_take_busy, in_valid_i && !in_stall_o, state_q == ST_BUSY, "take lost")
  `LOM_ASSERT_NEXT(a_last_idle, emit && last, state_q == ST_IDLE, "idle missed")
  `LOM_ASSERT_NOW(a_uncrossed, state_q == ST_IDLE && bid0.vld && ask0.vld,
                  bid0.price < ask0.price, "book crossed")
  `LOM_ASSERT_NOW(a_ins_room, own_op.ins, !own_full, "insert into full side")
endmodule

// File: sim/limit_order_matcher_tb.sv
// Testbench for limit_order_matcher: random and directed limit orders, results checked
// against a price-time priority book model kept in a scoreboard class.
// Depends on lom_pkg and the limit_order_matcher RTL.
`timescale 1ns / 1ps

module limit_order_matcher_tb;
  import lom_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } rest_t;

  class book_scoreboard;
    rest_t   bids[$];
    rest_t   asks[$];
    result_t fills_due[$];
    int      mismatches;

    function void push_fill(logic trade, logic [IdW-1:0] buy, logic [IdW-1:0] sell,
                            logic [PriceW-1:0] px, logic [QtyW-1:0] qty);
      result_t r;
      r = '0;
      r.has_trade = trade;
      r.buy_id = buy;
      r.sell_id = sell;
      r.trade_price = px;
      r.trade_quantity = qty;
      fills_due.insert(fills_due.size(), r);
    endfunction

    function void note_order(order_t o);
      logic [QtyW-1:0] left, t;
      status_e st;
      int n, pos, first;
      rest_t e;
      first = fills_due.size();
      left = o.quantity;
      st = STATUS_OK;
      if (left == 0) begin
        push_fill(1'b0, '0, '0, '0, '0);
        fills_due[first].status = STATUS_ZERO_QTY;
        fills_due[first].last = 1'b1;
        return;
      end
      if (!o.side) begin
        while (left > 0 && asks.size() > 0 && o.price >= asks[0].price) begin
          t = left < asks[0].qty ? left : asks[0].qty;
          push_fill(1'b1, o.order_id, asks[0].id, asks[0].price, t);
          left -= t;
          asks[0].qty -= t;
          if (asks[0].qty == 0) asks.delete(0);
        end
      end else begin
        while (left > 0 && bids.size() > 0 && bids[0].price >= o.price) begin
          t = left < bids[0].qty ? left : bids[0].qty;
          push_fill(1'b1, bids[0].id, o.order_id, o.price, t);
          left -= t;
          bids[0].qty -= t;
          if (bids[0].qty == 0) bids.delete(0);
        end
      end
      if (left > 0) begin
        e.id = o.order_id;
        e.price = o.price;
        e.qty = left;
        if (!o.side) begin
          if (bids.size() >= Depth) begin
            st = STATUS_FULL;
          end else begin
            pos = 0;
            while (pos < bids.size() && bids[pos].price >= o.price) pos++;
            bids.insert(pos, e);
          end
        end else begin
          if (asks.size() >= Depth) begin
            st = STATUS_FULL;
          end else begin
            pos = 0;
            while (pos < asks.size() && asks[pos].price <= o.price) pos++;
            asks.insert(pos, e);
          end
        end
      end
      if (fills_due.size() == first) push_fill(1'b0, '0, '0, '0, '0);
      n = fills_due.size() - 1;
      fills_due[n].status = st;
      fills_due[n].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (fills_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = fills_due[0];
      fills_due.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  order_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  book_scoreboard book = new();
  bit      hold_off = 1'b0;
  bit      stim_done = 1'b0;
  int      idle_cycles = 0;
  logic [IdW-1:0] next_id = 32'h10;

  limit_order_matcher i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_order(logic side, logic [PriceW-1:0] px, logic [QtyW-1:0] qty,
                            logic [IdW-1:0] id);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{side: side, order_id: id, price: px, quantity: qty};
    do @(posedge clk_i); while (in_stall_o);
    book.note_order(in_data_i);
  endtask

  task automatic send_near(logic side, logic [PriceW-1:0] px, logic [QtyW-1:0] qty);
    send_order(side, px, qty, next_id);
    next_id++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) book.check_result(out_data_o);
      if (idle_cycles >= IdleLimit) begin
        $display("** limit_order_matcher: FAILED **");
        $finish;
      end
    end
  end

  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, 4);
        if (stim_done || $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin : hold_window
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    int mode, base, k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_order(1'b0, 20'h0, 32'h0, 32'h0);
    send_order(1'b1, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_order(1'b0, 20'hFFFFF, 32'h1, 32'h1);
    send_order(1'b0, 20'hFFFFF, 32'hFFFFFFFF, 32'h2);
    send_order(1'b1, 20'h0, 32'hFFFFFFFF, 32'h3);
    send_order(1'b1, 20'h0, 32'h0, 32'h4);
    for (k = 0; k < 3; k++) send_near(1'b1, 20'd100 + 20'(k), 32'd5);
    send_near(1'b1, 20'd100, 32'd7);
    send_near(1'b0, 20'd101, 32'd14);
    send_near(1'b0, 20'd99, 32'd3);
    send_near(1'b0, 20'd99, 32'd4);
    send_near(1'b1, 20'd90, 32'd10);
    // fill asks past capacity, then send a large buy against them
    for (k = 0; k < Depth + 2; k++) send_near(1'b1, 20'd500 + 20'(k % 5), 32'd1 + 32'(k));
    send_near(1'b0, 20'hFFFFF, 32'hFFFFFFFF);
    send_near(1'b1, 20'h0, 32'hFFFFFFFF);
    for (k = 0; k < 230; k++) begin
      mode = $urandom_range(0, 9);
      base = 1000;
      if (mode == 0) begin
        send_order(1'($urandom_range(0, 1)), 20'($urandom), $urandom, $urandom);
      end else if (mode == 1) begin
        send_order(1'($urandom_range(0, 1)), 20'($urandom_range(base - 8, base + 8)),
                   $urandom_range(0, 1) ? 32'h0 : $urandom, $urandom);
      end else begin
        send_order(1'($urandom_range(0, 1)), 20'($urandom_range(base - 8, base + 8)),
                   $urandom_range(1, 40), $urandom);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    while (book.fills_due.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (book.mismatches == 0 && book.fills_due.size() == 0) begin
      $display("** limit_order_matcher: PASSED **");
    end else begin
      $display("** limit_order_matcher: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lom_pkg.sv
hdl/lom_cell.sv
hdl/lom_row.sv
hdl/limit_order_matcher.sv
sim/limit_order_matcher_tb.sv
